/* hw/rtl/days_between_dates_macros.svh */
// ---------------------------------------------------------------------------
// days_between_dates_macros.svh
// Assertion helpers shared by the date difference pipeline.
// ---------------------------------------------------------------------------
`ifndef DAYS_BETWEEN_DATES_MACROS_SVH
`define DAYS_BETWEEN_DATES_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define DBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dbd_pkg.sv */
// ---------------------------------------------------------------------------
// dbd_pkg
// Widths, calendar constants and month tables for the date difference block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dbd_pkg;

   localparam int DAY_W    = 5;
   localparam int MONTH_W  = 4;
   localparam int YEAR_W   = 14;
   localparam int QUART_W  = YEAR_W - 2;     // year / 4
   localparam int CENT_W   = 8;              // year / 100, max 163
   localparam int PROD_W   = 23;             // (year / 4) * reciprocal of 25
   localparam int REST_W   = 9;              // days before month + day + leap
   localparam int DNUM_W   = 23;             // absolute day number
   localparam int COUNT_W  = 24;             // signed difference
   localparam int STAGES   = 4;              // pipeline depth, output included

   localparam int DAYS_PER_YEAR = 365;
   localparam int RECIP_25      = 1311;      // ceil(2^15 / 25), exact for q < 4681
   localparam int RECIP_SHIFT   = 15;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [STAGES-1:0] en;     // stage load enables, stage 0 takes the input word
   } pipe_ctl_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         4'd12:   len = 5'd31;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [REST_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [REST_W-1:0] n;
      case (m)
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/dbd_pipe_ctrl.sv */
// ---------------------------------------------------------------------------
// dbd_pipe_ctrl
// Valid bits and per-stage load enables; a stage loads when it is empty or
// the stage after it moves.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "days_between_dates_macros.svh"

module dbd_pipe_ctrl
   import dbd_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output pipe_ctl_type      ctl
);

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] en;

   always_comb begin
      en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         en[i] = !valid_ff[i] || en[i+1];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (en[0]) begin
         valid_in[0] = req_valid;
      end
      for (int i = 1; i < STAGES; i++) begin
         if (en[i]) begin
            valid_in[i] = valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ctl.en    = en;
   assign req_ready = en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // a full stage blocked downstream keeps its word
   `DBD_ASSERT_NEXT(a_hold_s0, clock, reset, valid_ff[0] && !en[1], valid_ff[0], "stage 0 word lost")
   `DBD_ASSERT_NEXT(a_hold_s1, clock, reset, valid_ff[1] && !en[2], valid_ff[1], "stage 1 word lost")
   `DBD_ASSERT_NEXT(a_hold_s2, clock, reset, valid_ff[2] && !en[3], valid_ff[2], "stage 2 word lost")
   // accepted input lands in stage 0
   `DBD_ASSERT_NEXT(a_take, clock, reset, req_valid && req_ready, valid_ff[0], "input word dropped")

endmodule

`default_nettype wire

/* hw/rtl/dbd_date_num.sv */
// ---------------------------------------------------------------------------
// dbd_date_num
// Three-stage date check and day number: reciprocal products, then leap
// year and partial terms, then the final sum.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dbd_date_num
   import dbd_pkg::*;
(
   input  wire logic                 clock,
   input  wire pipe_ctl_type         ctl,
   input  wire logic [DAY_W-1:0]     day,
   input  wire logic [MONTH_W-1:0]   month,
   input  wire logic [YEAR_W-1:0]    year,
   output logic      [DNUM_W-1:0]    day_num,
   output logic                      date_ok
);

   // stage 1: offsets and /25 products
   logic [YEAR_W-1:0]  p1_in, p1_ff;
   logic [PROD_W-1:0]  pprod1_in, pprod1_ff;   // ((y-1)/4) * 1311
   logic [PROD_W-1:0]  yprod1_in, yprod1_ff;   // (y/4) * 1311
   logic [DAY_W-1:0]   d1_ff;
   logic [MONTH_W-1:0] m1_ff;
   logic [YEAR_W-1:0]  y1_ff;

   // stage 2: leap, check and partial terms
   logic [CENT_W-1:0]  pcent;
   logic [CENT_W-1:0]  ycent;
   logic [QUART_W-1:0] yrem;
   logic               leap;
   logic [DAY_W-1:0]   lim;
   logic [DNUM_W-1:0]  base2_in, base2_ff;
   logic [QUART_W-1:0] q2_ff;
   logic [CENT_W-1:0]  c2_ff;
   logic [REST_W-1:0]  rest2_in, rest2_ff;
   logic               ok2_in, ok2_ff;

   // stage 3: day number
   logic [DNUM_W-1:0]  num3_in, num3_ff;
   logic               ok3_ff;

   assign p1_in     = year - YEAR_W'(1);
   assign pprod1_in = PROD_W'({{(PROD_W-QUART_W){1'b0}}, p1_in[YEAR_W-1:2]}
                              * PROD_W'(RECIP_25));
   assign yprod1_in = PROD_W'({{(PROD_W-QUART_W){1'b0}}, year[YEAR_W-1:2]}
                              * PROD_W'(RECIP_25));

   always_ff @(posedge clock) begin
      if (ctl.en[0]) begin
         p1_ff     <= p1_in;
         pprod1_ff <= pprod1_in;
         yprod1_ff <= yprod1_in;
         d1_ff     <= day;
         m1_ff     <= month;
         y1_ff     <= year;
      end
   end

   always_comb begin
      pcent = pprod1_ff[PROD_W-1:RECIP_SHIFT];
      ycent = yprod1_ff[PROD_W-1:RECIP_SHIFT];
      // (y/4) mod 25; zero with y mod 4 zero means a century year
      yrem  = y1_ff[YEAR_W-1:2] - QUART_W'({{(QUART_W-CENT_W){1'b0}}, ycent} * QUART_W'(25));
      leap  = (y1_ff[1:0] == 2'd0) && ((yrem != '0) || (ycent[1:0] == 2'd0));
      lim   = month_len(m1_ff) + DAY_W'((m1_ff == MONTH_FEB) && leap);
      ok2_in = (m1_ff inside {[MONTH_JAN:MONTH_DEC]}) && (y1_ff != '0)
               && (d1_ff != '0) && (d1_ff <= lim);
      base2_in = DNUM_W'({{(DNUM_W-YEAR_W){1'b0}}, p1_ff} * DNUM_W'(DAYS_PER_YEAR));
      rest2_in = days_before(m1_ff) + REST_W'(d1_ff)
                 + REST_W'((m1_ff > MONTH_FEB) && leap);
   end

   always_ff @(posedge clock) begin
      if (ctl.en[1]) begin
         base2_ff <= base2_in;
         q2_ff    <= p1_ff[YEAR_W-1:2];
         c2_ff    <= pcent;
         rest2_ff <= rest2_in;
         ok2_ff   <= ok2_in;
      end
   end

   assign num3_in = base2_ff + DNUM_W'(q2_ff) - DNUM_W'(c2_ff)
                    + DNUM_W'(c2_ff[CENT_W-1:2]) + DNUM_W'(rest2_ff);

   always_ff @(posedge clock) begin
      if (ctl.en[2]) begin
         num3_ff <= num3_in;
         ok3_ff  <= ok2_ff;
      end
   end

   assign day_num = num3_ff;
   assign date_ok = ok3_ff;

endmodule

`default_nettype wire

/* hw/rtl/days_between_dates.sv */
// ---------------------------------------------------------------------------
// days_between_dates
// Signed Gregorian day count from a start date to an end date, both checked.
// ---------------------------------------------------------------------------
//
//   channel | dir | handshake             | word
//   --------+-----+-----------------------+------------------------------------
//   req_    | in  | req_valid / req_ready | start/end day, month, year
//   rsp_    | out | rsp_valid / rsp_ready | day_count (signed 24b), dates_valid
//
// Four register stages: reciprocal products, leap/check/partial terms,
// day number sum, difference into the output register. One word per cycle
// is sustained while rsp_ready holds, set by the stages with no shared
// unit.
// Reset (synchronous, active high) clears only the stage valid bits.
// Each stage loads when empty or when the stage after it moves, so a stall on
// rsp_ready fills bubbles first and never drops or repeats a word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module days_between_dates
   import dbd_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [DAY_W-1:0]         req_start_day,
   input  wire logic [MONTH_W-1:0]       req_start_month,
   input  wire logic [YEAR_W-1:0]        req_start_year,
   input  wire logic [DAY_W-1:0]         req_end_day,
   input  wire logic [MONTH_W-1:0]       req_end_month,
   input  wire logic [YEAR_W-1:0]        req_end_year,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [COUNT_W-1:0]     rsp_day_count,
   output logic                          rsp_dates_valid
);

   pipe_ctl_type ctl;

   logic [DNUM_W-1:0] start_num;
   logic [DNUM_W-1:0] end_num;
   logic              start_ok;
   logic              end_ok;

   logic signed [COUNT_W-1:0] count_in, count_ff;
   logic                      valid_in, valid_ff;

   // valid bits and stage enables
   dbd_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   // the two dates run side by side through the first three stages
   dbd_date_num u_start (
      .clock   (clock),
      .ctl     (ctl),
      .day     (req_start_day),
      .month   (req_start_month),
      .year    (req_start_year),
      .day_num (start_num),
      .date_ok (start_ok)
   );

   dbd_date_num u_end (
      .clock   (clock),
      .ctl     (ctl),
      .day     (req_end_day),
      .month   (req_end_month),
      .year    (req_end_year),
      .day_num (end_num),
      .date_ok (end_ok)
   );

   // stage 4: difference, forced to zero when either date fails its check
   always_comb begin
      valid_in = start_ok && end_ok;
      if (valid_in) begin
         count_in = $signed({1'b0, end_num}) - $signed({1'b0, start_num});
      end else begin
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en[STAGES-1]) begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_day_count   = count_ff;
   assign rsp_dates_valid = valid_ff;

endmodule

`default_nettype wire

/* sim/days_between_dates_checker.sv */
// ---------------------------------------------------------------------------
// days_between_dates_checker
// Watches both channels, predicts each signed day count and compares it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module days_between_dates_checker
   import dbd_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [DAY_W-1:0]          req_start_day,
   input  logic [MONTH_W-1:0]        req_start_month,
   input  logic [YEAR_W-1:0]         req_start_year,
   input  logic [DAY_W-1:0]          req_end_day,
   input  logic [MONTH_W-1:0]        req_end_month,
   input  logic [YEAR_W-1:0]         req_end_year,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [COUNT_W-1:0] rsp_day_count,
   input  logic                      rsp_dates_valid,
   output int                        mismatch_count,
   output int                        words_pending
);

   typedef struct packed {
      logic signed [COUNT_W-1:0] day_count;
      logic                      dates_valid;
   } day_count_type;

   day_count_type expected_counts[$];
   int failures      = 0;
   int pending_words = 0;

   assign mismatch_count = failures;
   assign words_pending  = pending_words;

   function automatic bit leap_year(input int y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   function automatic int month_length(input int m, input int y);
      int len;
      case (m)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11:           len = 30;
         2:                     len = leap_year(y) ? 29 : 28;
         default:               len = 0;
      endcase
      return len;
   endfunction

   // days in the months ahead of m, common year
   function automatic int days_ahead(input int m);
      int n;
      n = 0;
      for (int k = 1; k < m; k++) n += month_length(k, 1);
      return n;
   endfunction

   // day 1 is Jan 1 of year 1
   function automatic int ordinal_day(input int d, input int m, input int y);
      int p;
      p = y - 1;
      return 365 * p + p / 4 - p / 100 + p / 400 + days_ahead(m) + d
             + ((m > 2 && leap_year(y)) ? 1 : 0);
   endfunction

   function automatic bit date_in_calendar(input int d, input int m, input int y);
      return (m >= 1) && (m <= 12) && (y >= 1) && (d >= 1) && (d <= month_length(m, y));
   endfunction

   function automatic day_count_type predict_count(
      input int sd, input int sm, input int sy,
      input int ed, input int em, input int ey);
      day_count_type r;
      r = '0;
      if (date_in_calendar(sd, sm, sy) && date_in_calendar(ed, em, ey)) begin
         r.day_count   = COUNT_W'(ordinal_day(ed, em, ey) - ordinal_day(sd, sm, sy));
         r.dates_valid = 1'b1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR %0t ns: %s", $realtime, what);
      failures++;
   endtask

   always @(posedge clock) begin
      day_count_type want;
      if (reset) begin
         pending_words <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("unexpected word: day_count %0d dates_valid %0b",
                                         rsp_day_count, rsp_dates_valid));
            end else begin
               want = expected_counts.pop_front();
               if (rsp_day_count !== want.day_count)
                  report_mismatch($sformatf("day_count %0d, want %0d",
                                            rsp_day_count, want.day_count));
               if (rsp_dates_valid !== want.dates_valid)
                  report_mismatch($sformatf("dates_valid %0b, want %0b",
                                            rsp_dates_valid, want.dates_valid));
            end
         end
         if (req_valid && req_ready)
            expected_counts.push_back(predict_count(
               int'(req_start_day), int'(req_start_month), int'(req_start_year),
               int'(req_end_day), int'(req_end_month), int'(req_end_year)));
         pending_words <= expected_counts.size();
      end
   end

endmodule

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// testbench
// Date difference block: directed calendar corners, then random date pairs.
// A checker beside the block predicts every count; this top only drives
// words through both handshakes with random idling and gives the verdict.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import dbd_pkg::*;

   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
   } date_type;

   // every input known from time zero
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [DAY_W-1:0]          req_start_day = '0;
   logic [MONTH_W-1:0]        req_start_month = '0;
   logic [YEAR_W-1:0]         req_start_year = '0;
   logic [DAY_W-1:0]          req_end_day = '0;
   logic [MONTH_W-1:0]        req_end_month = '0;
   logic [YEAR_W-1:0]         req_end_year = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [COUNT_W-1:0] rsp_day_count;
   logic                      rsp_dates_valid;

   int mismatch_count;
   int words_pending;

   // idle style of each side, redrawn every 50 words:
   // 0 = back to back, 1 = uniform 0..16, 2 = mostly back to back
   int req_mode = 0;
   int rsp_mode = 0;

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   days_between_dates DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_day   (req_start_day),
      .req_start_month (req_start_month),
      .req_start_year  (req_start_year),
      .req_end_day     (req_end_day),
      .req_end_month   (req_end_month),
      .req_end_year    (req_end_year),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_day_count   (rsp_day_count),
      .rsp_dates_valid (rsp_dates_valid)
   );

   days_between_dates_checker date_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_start_day   (req_start_day),
      .req_start_month (req_start_month),
      .req_start_year  (req_start_year),
      .req_end_day     (req_end_day),
      .req_end_month   (req_end_month),
      .req_end_year    (req_end_year),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_day_count   (rsp_day_count),
      .rsp_dates_valid (rsp_dates_valid),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   function automatic int draw_gap(input int mode);
      int gap;
      case (mode)
         0:       gap = 0;
         1:       gap = $urandom_range(0, 16);
         default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
      endcase
      return gap;
   endfunction

   function automatic date_type cal_date(input int d, input int m, input int y);
      date_type t;
      t.day   = DAY_W'(d);
      t.month = MONTH_W'(m);
      t.year  = YEAR_W'(y);
      return t;
   endfunction

   // month length for building well-formed dates on the stimulus side
   function automatic int last_day(input int m, input int y);
      int len;
      case (m)
         2:           len = (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
         4, 6, 9, 11: len = 30;
         default:     len = 31;
      endcase
      return len;
   endfunction

   // years lean on century and 400-year boundaries and on both ends of the range
   function automatic int pick_year();
      int y;
      case ($urandom_range(0, 3))
         0:       y = $urandom_range(1, 16383);
         1:       y = $urandom_range(1890, 2110);
         2:       y = $urandom_range(1, 163) * 100 - 1 + $urandom_range(0, 2);
         default: y = $urandom_range(0, 1) ? $urandom_range(1, 8) : $urandom_range(16376, 16383);
      endcase
      return y;
   endfunction

   function automatic date_type good_date();
      int y;
      int m;
      int lim;
      y   = pick_year();
      m   = $urandom_range(1, 12);
      lim = last_day(m, y);
      // a quarter of the days land on the month's last day
      return cal_date(($urandom_range(0, 3) == 0) ? lim : $urandom_range(1, lim), m, y);
   endfunction

   // a well-formed date with one field pushed out of the calendar, or raw bits
   function automatic date_type broken_date();
      date_type t;
      int lim;
      t   = good_date();
      lim = last_day(int'(t.month), int'(t.year));
      case ($urandom_range(0, 4))
         0: t.day = '0;
         1: t.day = (lim < 31) ? DAY_W'($urandom_range(lim + 1, 31)) : '0;
         2: t.month = $urandom_range(0, 1) ? '0 : MONTH_W'($urandom_range(13, 15));
         3: t.year = '0;
         default: begin
            t.day   = DAY_W'($urandom);
            t.month = MONTH_W'($urandom);
            t.year  = YEAR_W'($urandom);
         end
      endcase
      return t;
   endfunction

   // Called and returns at a falling edge. A gap lowers valid first; with no
   // gap valid stays high and only the payload moves, one assignment per step.
   task automatic send_dates(input date_type s, input date_type e);
      int gap;
      gap = draw_gap(req_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_start_day   <= s.day;
      req_start_month <= s.month;
      req_start_year  <= s.year;
      req_end_day     <= e.day;
      req_end_month   <= e.month;
      req_end_year    <= e.year;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Receiver: its own idle draw per word, plus one long hold-off after 300
   // words so the pipe fills and req_ready drops while words keep coming.
   initial begin
      int taken;
      int stall;
      taken = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (taken % 50 == 0) rsp_mode = $urandom_range(0, 2);
         stall = (taken == 300) ? 400 : draw_gap(rsp_mode);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
         @(negedge clock);
      end
   end

   // Main sequence: reset, directed corners, random pairs, drain, verdict.
   initial begin
      date_type s;
      date_type e;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // same date, smallest and largest valid dates both ways
      send_dates(cal_date(1, 1, 1), cal_date(1, 1, 1));
      send_dates(cal_date(1, 1, 1), cal_date(31, 12, 16383));
      send_dates(cal_date(31, 12, 16383), cal_date(1, 1, 1));
      // leap day: divisible by 400, plain century, ordinary leap and common year
      send_dates(cal_date(29, 2, 2000), cal_date(1, 3, 2000));
      send_dates(cal_date(28, 2, 1900), cal_date(29, 2, 1900));
      send_dates(cal_date(29, 2, 2024), cal_date(1, 3, 2025));
      send_dates(cal_date(1, 1, 2023), cal_date(29, 2, 2023));
      // year rollover and start after end
      send_dates(cal_date(31, 12, 1999), cal_date(1, 1, 2000));
      send_dates(cal_date(15, 6, 2020), cal_date(1, 1, 2000));
      // day out of range: zero and 31 in a 30-day month; 31 in a 31-day month is in range
      send_dates(cal_date(0, 5, 2010), cal_date(1, 5, 2010));
      send_dates(cal_date(1, 4, 2010), cal_date(31, 4, 2010));
      send_dates(cal_date(31, 1, 2010), cal_date(30, 11, 2010));
      send_dates(cal_date(30, 11, 2010), cal_date(31, 11, 2010));
      // month zero, 13 and 15; year zero on either side
      send_dates(cal_date(1, 0, 2000), cal_date(1, 1, 2000));
      send_dates(cal_date(1, 1, 2000), cal_date(1, 13, 2000));
      send_dates(cal_date(1, 15, 2000), cal_date(1, 1, 2000));
      send_dates(cal_date(1, 1, 0), cal_date(1, 1, 1));
      send_dates(cal_date(1, 1, 1), cal_date(1, 1, 0));
      // all fields at zero and at their top codes
      send_dates(cal_date(0, 0, 0), cal_date(0, 0, 0));
      send_dates(cal_date(31, 15, 16383), cal_date(31, 15, 16383));
      send_dates(cal_date(31, 12, 16383), cal_date(31, 12, 16383));

      // mostly well-formed pairs; an eighth share month and year (half of those the whole date), a quarter are broken
      for (int n = 0; n < 1550; n++) begin
         if (n % 50 == 0) req_mode = $urandom_range(0, 2);
         s = good_date();
         e = good_date();
         case ($urandom_range(0, 7))
            0: begin
               e = s;
               if ($urandom_range(0, 1)) e.day = DAY_W'($urandom_range(1, 28));
            end
            1: s = broken_date();
            2: e = broken_date();
            default: ;
         endcase
         send_dates(s, e);
      end

      // send_dates returns at the falling edge right after acceptance
      req_valid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      // wait on past the drain to catch any stray word
      repeat (2 * STAGES + 4) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // watchdog, several times the slowest legal run
   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
